// ===== hdl/gnmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gnmc_pkg: shared constants and types
// Widths, character codes, register indexes and the structs that travel
// between the configuration block, the column cells and the top level.
// ----------------------------------------------------------------------------
package gnmc_pkg;

	localparam int MAX_COLS = 32;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = 8;
	localparam int CHAR_W   = 8;
	localparam int CCNT_W   = 6;
	localparam int CNT_W    = 4;
	localparam int SLOTS    = 4;
	localparam int SLOT_W   = 2;
	localparam int DIST_W   = 2;
	localparam int AVAIL_W  = $clog2(3 * MAX_COLS + 3);
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam logic [CHAR_W-1:0] MINE_CHAR = 8'd42;
	localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'd48;

	localparam logic [ROW_W-1:0]  ROW_COUNT_RST = 8'd5;
	localparam logic [CCNT_W-1:0] COL_COUNT_RST = 6'd5;
	localparam logic [ROW_W-1:0]  ROW_MIN       = 8'd3;
	localparam logic [CCNT_W-1:0] COL_MIN       = 6'd3;
	localparam logic [CCNT_W-1:0] COL_LIMIT     = CCNT_W'(MAX_COLS - 1);

	// register index, taken from paddr[2]
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	// input row may run at most this many rows ahead of the result row
	localparam logic [DIST_W-1:0] DIST_FULL = 2'd3;

	typedef struct packed {
		logic [ROW_W-1:0] rows;
		logic [COL_W-1:0] cols;
		logic             restart;
	} gnmc_cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              mine;
	} gnmc_wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              up_ok;
		logic              dn_ok;
	} gnmc_view_t;

	typedef struct packed {
		logic             mine;
		logic [CNT_W-1:0] count;
	} gnmc_cnt_t;

endpackage
`default_nettype wire

// ===== hdl/gnmc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gnmc_cfg: configuration registers
// APB-style row_count / col_count registers, readback, the clamped grid
// size and a restart pulse on every write.
// ----------------------------------------------------------------------------
module gnmc_cfg import gnmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output gnmc_cfg_t         cfg
);

	logic [ROW_W-1:0]  row_count_q;
	logic [CCNT_W-1:0] col_count_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ROW_COUNT: row_count_q <= pwdata[ROW_W-1:0];
				REG_COL_COUNT: col_count_q <= pwdata[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			case (paddr[2])
				REG_ROW_COUNT: prdata = DATA_W'(row_count_q);
				REG_COL_COUNT: prdata = DATA_W'(col_count_q);
				default:       prdata = '0;
			endcase
		end
	end

	always_comb begin
		cfg.restart = wr_en;
		cfg.rows    = (row_count_q < ROW_MIN) ? ROW_MIN : row_count_q;
		if (col_count_q < COL_MIN) begin
			cfg.cols = COL_W'(COL_MIN);
		end else if (col_count_q > COL_LIMIT) begin
			cfg.cols = COL_W'(COL_LIMIT);
		end else begin
			cfg.cols = COL_W'(col_count_q);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/gnmc_col_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gnmc_col_cell: one grid column
// Holds the mine bits of one column for four rolling rows, hands its
// vertical slice to both neighbors and forms the 3x3 count for its column.
// ----------------------------------------------------------------------------
module gnmc_col_cell import gnmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       wr_en,
	input  gnmc_wr_t   wr,
	input  gnmc_view_t view,
	input  logic [2:0] left_vert,
	input  logic [2:0] right_vert,
	input  logic       right_ok,
	output logic [2:0] vert,
	output gnmc_cnt_t  res
);

	logic [SLOTS-1:0] bits_q;
	logic             up;
	logic             mid;
	logic             dn;
	logic [2:0]       rv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (clr) begin
			bits_q <= '0;
		end else if (wr_en) begin
			bits_q[wr.slot] <= wr.mine;
		end
	end

	always_comb begin
		up   = bits_q[view.slot - SLOT_W'(1)] & view.up_ok;
		mid  = bits_q[view.slot];
		dn   = bits_q[view.slot + SLOT_W'(1)] & view.dn_ok;
		vert = {up, mid, dn};
		// drop the right neighbor past the last grid column
		rv   = right_ok ? right_vert : 3'b000;
		res.mine  = mid;
		res.count = CNT_W'(up) + CNT_W'(dn)
			+ CNT_W'(left_vert[0]) + CNT_W'(left_vert[1]) + CNT_W'(left_vert[2])
			+ CNT_W'(rv[0]) + CNT_W'(rv[1]) + CNT_W'(rv[2]);
	end

endmodule
`default_nettype wire

// ===== hdl/grid_neighbor_mine_count.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbor_mine_count: streaming 3x3 mine counter
// Raster cells in, one count character per cell out, with row, frame and
// run marks.
// ----------------------------------------------------------------------------
// Usage:
//   Cell beats (cell_valid/cell_ready, cell_char) arrive in raster order.
//   Result beats (res_valid/res_ready) carry out_char, row_end, frame_end
//   and run_last in raster order of the grid.
//   Throughput: one cell beat and one result beat per cycle while neither
//   channel stalls, set by the row of column cells that forms one 3x3
//   count per cycle. A result is registered after the cell beat that
//   completes its lower-right neighbor is accepted. The last cell of a frame
//   releases the clamped col_count + 2 results, which leave at one per
//   cycle unless res_ready stalls, while the next frame's first row comes in.
//   Mine bits sit in four rolling rows; cell_ready drops while the input
//   is three rows ahead of the result being formed, so a receiver that
//   stalls res_ready stops the input once it is three rows ahead.
//   Reset, and any configuration write, clears all positions, the mine
//   rows and the result valid flag; row_count and col_count reset to 5.
// ----------------------------------------------------------------------------
module grid_neighbor_mine_count import gnmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              cell_valid,
	output logic              cell_ready,
	input  logic [CHAR_W-1:0] cell_char,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              row_end,
	output logic              frame_end,
	output logic              run_last
);

	gnmc_cfg_t cfg;

	logic [ROW_W-1:0]   in_row_q;
	logic [COL_W-1:0]   in_col_q;
	logic [SLOT_W-1:0]  islot_q;
	logic [ROW_W-1:0]   o_row_q;
	logic [COL_W-1:0]   o_col_q;
	logic [SLOT_W-1:0]  gslot_q;
	logic [AVAIL_W-1:0] avail_q;
	logic [DIST_W-1:0]  dist_q;
	logic               res_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               row_end_q;
	logic               frame_end_q;
	logic               run_last_q;

	logic               in_fire;
	logic               gen_go;
	logic               in_last_col;
	logic               in_last_row;
	logic               o_last_col;
	logic               o_last_row;
	logic [AVAIL_W-1:0] rel;
	gnmc_wr_t           wr;
	gnmc_view_t         view;
	gnmc_cnt_t          sel;

	logic [2:0]         vert    [MAX_COLS];
	gnmc_cnt_t          res_arr [MAX_COLS];

	gnmc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign cell_ready  = (dist_q != DIST_FULL);
	assign in_fire     = cell_valid & cell_ready;
	assign gen_go      = (avail_q != '0) & (~res_valid_q | res_ready);
	assign in_last_col = (in_col_q == cfg.cols - COL_W'(1));
	assign in_last_row = (in_row_q == cfg.rows - ROW_W'(1));
	assign o_last_col  = (o_col_q == cfg.cols - COL_W'(1));
	assign o_last_row  = (o_row_q == cfg.rows - ROW_W'(1));

	// results released by the current cell beat
	always_comb begin
		rel = '0;
		if (in_row_q != '0 && in_col_q != '0) begin
			if (!in_last_col) begin
				rel = AVAIL_W'(1);
			end else if (in_last_row) begin
				rel = AVAIL_W'(cfg.cols) + AVAIL_W'(2);
			end else begin
				rel = AVAIL_W'(2);
			end
		end
	end

	assign wr.slot    = islot_q;
	assign wr.mine    = (cell_char == MINE_CHAR);
	assign view.slot  = gslot_q;
	assign view.up_ok = (o_row_q != '0);
	assign view.dn_ok = ~o_last_row;

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
		logic [2:0] lv;
		logic [2:0] rvin;
		logic       rok;
		if (j == 0) begin : g_first
			assign lv = 3'b000;
		end else begin : g_mid
			assign lv = vert[j-1];
		end
		if (j == MAX_COLS - 1) begin : g_last
			assign rvin = 3'b000;
		end else begin : g_inner
			assign rvin = vert[j+1];
		end
		assign rok = ((COL_W+1)'(j + 1) < {1'b0, cfg.cols});

		gnmc_col_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.clr        (cfg.restart),
			.wr_en      (in_fire && (in_col_q == COL_W'(j))),
			.wr         (wr),
			.view       (view),
			.left_vert  (lv),
			.right_vert (rvin),
			.right_ok   (rok),
			.vert       (vert[j]),
			.res        (res_arr[j])
		);
	end

	assign sel = res_arr[o_col_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			islot_q     <= '0;
			o_row_q     <= '0;
			o_col_q     <= '0;
			gslot_q     <= '0;
			avail_q     <= '0;
			dist_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (cfg.restart) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			islot_q     <= '0;
			o_row_q     <= '0;
			o_col_q     <= '0;
			gslot_q     <= '0;
			avail_q     <= '0;
			dist_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (in_last_col) begin
					in_col_q <= '0;
					islot_q  <= islot_q + SLOT_W'(1);
					in_row_q <= in_last_row ? '0 : in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (gen_go) begin
				if (o_last_col) begin
					o_col_q <= '0;
					gslot_q <= gslot_q + SLOT_W'(1);
					o_row_q <= o_last_row ? '0 : o_row_q + ROW_W'(1);
				end else begin
					o_col_q <= o_col_q + COL_W'(1);
				end
			end
			avail_q <= avail_q + (in_fire ? rel : '0) - AVAIL_W'(gen_go);
			dist_q  <= dist_q + DIST_W'(in_fire & in_last_col)
				- DIST_W'(gen_go & o_last_col);
			if (gen_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded when a new beat is formed
	always_ff @(posedge clk) begin
		if (gen_go) begin
			out_char_q  <= sel.mine ? MINE_CHAR : ZERO_CHAR + CHAR_W'(sel.count);
			row_end_q   <= o_last_col;
			frame_end_q <= o_last_col & o_last_row;
			// hold the mark where the same cell beat releases the next result too
			run_last_q  <= ~((o_col_q == cfg.cols - COL_W'(2))
				| ((o_row_q == cfg.rows - ROW_W'(2)) & o_last_col)
				| (o_last_row & ~o_last_col));
		end
	end

	assign res_valid = res_valid_q;
	assign out_char  = out_char_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule
`default_nettype wire

// ===== hdl/gnmc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gnmc_checker: port-level checks
// Watches the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
module gnmc_checker import gnmc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic              res_valid,
	input logic              res_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              row_end,
	input logic              frame_end,
	input logic              run_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_char)
			&& $stable(row_end) && $stable(frame_end) && $stable(run_last))
		else $error("result beat changed while stalled");

	a_frame_marks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> row_end && run_last)
		else $error("frame end without row end and run mark");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid during reset");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !res_valid)
		else $error("result valid after configuration write");

endmodule

bind grid_neighbor_mine_count gnmc_checker u_gnmc_checker (.*);
`default_nettype wire

// ===== bench/tb_grid_neighbor_mine_count.sv =====
// ----------------------------------------------------------------------------
// tb_grid_neighbor_mine_count: bench for the streaming 3x3 mine counter
// Cells go in through a valid/ready channel and the count characters come
// back in raster order. A bench-side mirror of the grid, its mine rows and
// its read and write positions predicts every result beat, and each beat is
// checked field by field. Both channels stall at random except in the
// back-to-back test, grid sizes are set over the APB port between phases,
// and the extremes of both registers are covered.
// ----------------------------------------------------------------------------
module tb_grid_neighbor_mine_count;
	import gnmc_pkg::*;

	localparam int                STALL_PCT   = 24;
	localparam int                QUIET_LIMIT = 2000;
	localparam int                DRAIN_WAIT  = 4;
	localparam int                RANDOM_CELLS = 330;
	localparam int                REG_SEL_BIT = 2;
	localparam logic [ADDR_W-1:0] ROW_COUNT_ADDR = {REG_ROW_COUNT, 2'b00};
	localparam logic [ADDR_W-1:0] COL_COUNT_ADDR = {REG_COL_COUNT, 2'b00};

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              row_end;
		logic              frame_end;
		logic              run_last;
	} count_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              cell_valid = 1'b0;
	logic              cell_ready;
	logic [CHAR_W-1:0] cell_char = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic              row_end;
	logic              frame_end;
	logic              run_last;

	// grid mirror
	logic [ROW_W-1:0]    cfg_rows = ROW_COUNT_RST;
	logic [CCNT_W-1:0]   cfg_cols = COL_COUNT_RST;
	logic [MAX_COLS-1:0] mine_bits [3];
	int                  in_r, in_c, out_r, out_c;
	count_beat_t         due_counts [$];

	int   errors = 0;
	int   quiet_cycles = 0;
	logic steady = 1'b0;

	grid_neighbor_mine_count dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_char  (cell_char),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_char   (out_char),
		.row_end    (row_end),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

	always #5 clk = ~clk;

	function automatic int grid_rows();
		return (cfg_rows < ROW_MIN) ? int'(ROW_MIN) : int'(cfg_rows);
	endfunction

	function automatic int grid_cols();
		if (cfg_cols < COL_MIN) return int'(COL_MIN);
		if (cfg_cols > COL_LIMIT) return int'(COL_LIMIT);
		return int'(cfg_cols);
	endfunction

	function automatic void restart_frame();
		for (int i = 0; i < 3; i++) mine_bits[i] = '0;
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
	endfunction

	function automatic logic [CHAR_W-1:0] count_char(int r, int c, int rows, int cols);
		int n;
		int nr, nc;
		n = 0;
		if (mine_bits[r % 3][c]) return MINE_CHAR;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				nr = r + dr;
				nc = c + dc;
				if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= rows || nc >= cols)
					continue;
				if (mine_bits[nr % 3][nc]) n++;
			end
		end
		return ZERO_CHAR + CHAR_W'(n);
	endfunction

	// Queue every count released by one accepted cell.
	function automatic void predict_counts(logic [CHAR_W-1:0] ch);
		int          rows, cols, cr, cc, lr, lc;
		bit          held;
		count_beat_t beat;
		rows = grid_rows();
		cols = grid_cols();
		held = 1'b0;
		if (in_r >= rows || in_c >= cols) begin
			in_r = 0;
			in_c = 0;
			out_r = 0;
			out_c = 0;
		end
		cr = in_r;
		cc = in_c;
		mine_bits[cr % 3][cc] = (ch == MINE_CHAR);
		while (out_r < rows) begin
			lr = (out_r + 1 < rows) ? out_r + 1 : rows - 1;
			lc = (out_c + 1 < cols) ? out_c + 1 : cols - 1;
			if (!(lr < cr || (lr == cr && lc <= cc))) break;
			if (held) due_counts.push_back(beat);
			held = 1'b1;
			beat.ch = count_char(out_r, out_c, rows, cols);
			beat.row_end = (out_c == cols - 1);
			beat.frame_end = (out_c == cols - 1) && (out_r == rows - 1);
			beat.run_last = 1'b0;
			if (out_c == cols - 1) begin
				out_c = 0;
				out_r++;
			end else begin
				out_c++;
			end
		end
		if (held) begin
			beat.run_last = 1'b1;
			due_counts.push_back(beat);
		end
		if (cc == cols - 1) begin
			in_c = 0;
			if (cr == rows - 1) begin
				in_r = 0;
				out_r = 0;
				out_c = 0;
			end else begin
				in_r = cr + 1;
			end
		end else begin
			in_c = cc + 1;
		end
	endfunction

	// Called at a clock edge; returns at the edge that accepts the beat.
	task automatic send_cell(input logic [CHAR_W-1:0] ch);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_char <= ch;
		do @(posedge clk); while (!cell_ready);
		predict_counts(ch);
	endtask

	// Drop valid and wait until every predicted count has come back.
	task automatic settle();
		cell_valid <= 1'b0;
		while (due_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[REG_SEL_BIT] == REG_ROW_COUNT) cfg_rows = data[ROW_W-1:0];
		else cfg_cols = data[CCNT_W-1:0];
		restart_frame();
		@(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_cell(int density);
		logic [CHAR_W-1:0] ch;
		if ($urandom_range(0, 99) < density) return MINE_CHAR;
		do ch = CHAR_W'($urandom_range(0, 255)); while (ch == MINE_CHAR);
		return ch;
	endfunction

	// Reset sizes are 5 by 5; stop partway through the frame.
	task automatic test_reset_values();
		logic [CHAR_W-1:0] cells [12] = '{MINE_CHAR, 8'd0, 8'd255, MINE_CHAR, 8'd43,
			8'd41, MINE_CHAR, MINE_CHAR, 8'd128, MINE_CHAR, 8'd1, 8'd170};
		foreach (cells[i]) send_cell(cells[i]);
	endtask

	// Restart mid-frame and clamp both sizes up to 3: a ring of mines gives an 8.
	task automatic test_restart_small_grid();
		logic [CHAR_W-1:0] cells [9] = '{MINE_CHAR, MINE_CHAR, MINE_CHAR, MINE_CHAR,
			8'd0, MINE_CHAR, MINE_CHAR, MINE_CHAR, MINE_CHAR};
		settle();
		write_register(ROW_COUNT_ADDR, DATA_W'(1));
		write_register(COL_COUNT_ADDR, DATA_W'(0));
		foreach (cells[i]) send_cell(cells[i]);
	endtask

	// Two frames with both sides running flat out.
	task automatic test_back_to_back();
		int density;
		settle();
		write_register(ROW_COUNT_ADDR, DATA_W'(4));
		write_register(COL_COUNT_ADDR, DATA_W'(6));
		steady = 1'b1;
		density = $urandom_range(10, 60);
		repeat (2 * grid_rows() * grid_cols()) send_cell(random_cell(density));
		settle();
		steady = 1'b0;
	endtask

	// Phases of random frames, the register extremes first.
	task automatic test_random_frames();
		logic [ROW_W-1:0]  corner_rows [7] = '{8'd0, 8'd255, 8'd3, 8'd2, 8'd255, 8'd3, 8'd1};
		logic [CCNT_W-1:0] corner_cols [7] = '{6'd0, 6'd63, 6'd32, 6'd31, 6'd3, 6'd3, 6'd63};
		logic [DATA_W-1:0] data;
		int                sent, phase, mode, frame, n, density;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_CELLS) begin
			settle();
			mode = (phase < 7) ? 0 : $urandom_range(0, 3);
			if (mode == 0 || mode == 1) begin
				data = $urandom();
				if (phase < 7) data[ROW_W-1:0] = corner_rows[phase];
				else data[ROW_W-1:0] = ($urandom_range(0, 99) < 10) ? ROW_W'(255) :
					ROW_W'($urandom_range(0, 10));
				write_register(ROW_COUNT_ADDR, data);
			end
			if (mode == 0 || mode == 2) begin
				data = $urandom();
				if (phase < 7) data[CCNT_W-1:0] = corner_cols[phase];
				else data[CCNT_W-1:0] = ($urandom_range(0, 99) < 15) ?
					CCNT_W'($urandom_range(32, 63)) : CCNT_W'($urandom_range(0, 12));
				write_register(COL_COUNT_ADDR, data);
			end
			frame = grid_rows() * grid_cols();
			// keep the extreme sizes short so every one of them gets its turn
			if (phase < 7) begin
				n = $urandom_range(20, 45);
			end else if (frame <= 150) begin
				n = frame * $urandom_range(1, 2);
				if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame - 1);
			end else begin
				n = $urandom_range(30, 120);
			end
			if (n > RANDOM_CELLS - sent) n = RANDOM_CELLS - sent;
			density = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(0, 1) :
				$urandom_range(5, 70);
			repeat (n) send_cell(random_cell(density));
			sent += n;
			phase++;
		end
	endtask

	always @(posedge clk) begin
		res_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
	end

	always @(posedge clk) begin : check_counts
		count_beat_t want;
		if (arst_n && res_valid && res_ready) begin
			if (due_counts.size() == 0) begin
				$error("unexpected result beat: out_char %0d", out_char);
				errors++;
			end else begin
				want = due_counts.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char expected %0d actual %0d", want.ch, out_char);
					errors++;
				end
				if (row_end !== want.row_end) begin
					$error("row_end expected %0d actual %0d", want.row_end, row_end);
					errors++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end expected %0d actual %0d", want.frame_end, frame_end);
					errors++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last expected %0d actual %0d", want.run_last, run_last);
					errors++;
				end
			end
		end
	end

	// End the run if no beat of any kind moves for too long.
	always @(posedge clk) begin
		if ((cell_valid && cell_ready) || (res_valid && res_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		restart_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_restart_small_grid();
		test_back_to_back();
		test_random_frames();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
